### hdl/htbd_pkg.sv
`timescale 1ns / 1ps
// shared constants, operation codes and state codes for the huffman tree bit decoder
// no dependencies; imported by huffman_tree_bit_decoder

package htbd_pkg;

    // tree geometry
    localparam int SYMBOL_COUNT = 64;
    localparam int ROOT_NODE    = 126;
    localparam int TREE_DEPTH   = ROOT_NODE - SYMBOL_COUNT + 1;
    localparam int SLOT_W       = 6;
    localparam int NODE_W       = 7;
    localparam int SYM_W        = 6;
    localparam int BYTE_W       = 8;
    localparam int CNT_W        = 3;
    localparam int OP_W         = 2;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_DECODE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // register index of end_symbol
    localparam logic REG_END_SYMBOL = 1'b0;

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_STEP  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    localparam logic [NODE_W-1:0] ROOT_CODE = NODE_W'(ROOT_NODE);

endpackage

### hdl/huffman_tree_bit_decoder.sv
`timescale 1ns / 1ps
// huffman tree bit decoder: tree load, bit-serial walk and symbol output
// depends on htbd_pkg

// A load or clear word is taken while the block is idle and leaves it idle. A
// decode word walks its eight bits one at a time, most significant first; each bit
// goes through a registered read of the child memories and then the step. After the
// eighth bit a flush state hands over the byte's final symbol; out_stall can hold
// back a step or the flush. Up to eight symbols come out per byte, the final one
// marked with last. Clear empties the tree at once through per-node valid flags. The
// user is to set end_symbol over the APB port while the block is idle; the block itself does not enforce this.
module huffman_tree_bit_decoder
    import htbd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OP_W-1:0]     operation,
    input  logic [NODE_W-1:0]   node_index,
    input  logic [NODE_W-1:0]   parent_index,
    input  logic [BYTE_W-1:0]   data_byte,
    // output channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic [SYM_W-1:0]    symbol,
    output logic                is_end,
    output logic                last,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    // child memories and per-node valid flags
    logic [NODE_W-1:0]     left_mem  [TREE_DEPTH];
    logic [NODE_W-1:0]     right_mem [TREE_DEPTH];
    logic [TREE_DEPTH-1:0] lseen_reg;
    logic [TREE_DEPTH-1:0] rseen_reg;

    // control and data registers
    logic [1:0]        state_reg, state_next;
    logic [NODE_W-1:0] walk_reg, walk_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [SYM_W-1:0]  pend_sym_reg, pend_sym_next;
    logic              pend_end_reg, pend_end_next;
    logic              out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]  out_sym_reg, out_sym_next;
    logic              out_end_reg, out_end_next;
    logic              out_last_reg, out_last_next;
    logic [SYM_W-1:0]  end_sym_reg;

    // read stage registers
    logic [NODE_W-1:0] rd_left_reg, rd_right_reg;
    logic              rd_lval_reg, rd_rval_reg, rd_hit_reg;

    // handshake terms
    logic in_accept;
    logic out_take;
    logic out_free;
    logic cfg_write;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_write = psel && penable && pwrite && pready;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[APB_AW-1] == REG_END_SYMBOL)
                    ? {{(APB_DW-SYM_W){1'b0}}, end_sym_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_sym_reg <= '0;
        end
        else if (cfg_write && paddr[APB_AW-1] == REG_END_SYMBOL)
        begin
            end_sym_reg <= pwdata[SYM_W-1:0];
        end
    end

    // load decode
    logic              parent_hit;
    logic [SLOT_W-1:0] wr_slot;
    logic              load_wr;
    logic              wr_left;
    logic              wr_right;
    logic              clear_go;

    assign parent_hit = (parent_index >= NODE_W'(SYMBOL_COUNT))
                        && (parent_index <= ROOT_CODE);
    assign wr_slot    = SLOT_W'(parent_index - NODE_W'(SYMBOL_COUNT));
    assign load_wr    = in_accept && (operation == OP_LOAD) && parent_hit;
    assign wr_left    = load_wr && !lseen_reg[wr_slot];
    assign wr_right   = load_wr && lseen_reg[wr_slot];
    assign clear_go   = in_accept && (operation == OP_CLEAR);

    // walk address
    logic              walk_hit;
    logic [SLOT_W-1:0] walk_slot;

    assign walk_hit  = (walk_reg >= NODE_W'(SYMBOL_COUNT)) && (walk_reg <= ROOT_CODE);
    assign walk_slot = SLOT_W'(walk_reg - NODE_W'(SYMBOL_COUNT));

    // child memories: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_left)
        begin
            left_mem[wr_slot] <= node_index;
        end
        if (wr_right)
        begin
            right_mem[wr_slot] <= node_index;
        end
        if (state_reg == ST_READ && walk_hit)
        begin
            rd_left_reg  <= left_mem[walk_slot];
            rd_right_reg <= right_mem[walk_slot];
        end
    end

    // valid flags and their read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lseen_reg   <= '0;
            rseen_reg   <= '0;
            rd_lval_reg <= 1'b0;
            rd_rval_reg <= 1'b0;
            rd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (clear_go)
            begin
                lseen_reg <= '0;
                rseen_reg <= '0;
            end
            else
            begin
                if (wr_left)
                begin
                    lseen_reg[wr_slot] <= 1'b1;
                end
                if (wr_right)
                begin
                    rseen_reg[wr_slot] <= 1'b1;
                end
            end
            if (state_reg == ST_READ)
            begin
                rd_hit_reg <= walk_hit;
                if (walk_hit)
                begin
                    rd_lval_reg <= lseen_reg[walk_slot];
                    rd_rval_reg <= rseen_reg[walk_slot];
                end
            end
        end
    end

    // child chosen by the current bit
    logic              choice;
    logic [NODE_W-1:0] child;
    logic              is_leaf;

    assign choice = shift_reg[BYTE_W-1];

    always_comb
    begin
        child = '0;
        if (rd_hit_reg)
        begin
            if (choice)
            begin
                child = rd_rval_reg ? rd_right_reg : '0;
            end
            else
            begin
                child = rd_lval_reg ? rd_left_reg : '0;
            end
        end
    end

    assign is_leaf = (child < NODE_W'(SYMBOL_COUNT));

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        walk_next       = walk_reg;
        shift_next      = shift_reg;
        bit_cnt_next    = bit_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        pend_end_next   = pend_end_reg;
        out_valid_next  = out_take ? 1'b0 : out_valid_reg;
        out_sym_next    = out_sym_reg;
        out_end_next    = out_end_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (operation)
                        OP_DECODE:
                        begin
                            shift_next   = data_byte;
                            bit_cnt_next = '0;
                            state_next   = ST_READ;
                        end
                        OP_CLEAR:
                        begin
                            walk_next = ROOT_CODE;
                        end
                        default:
                        begin
                            walk_next = walk_reg;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                // a leaf pushes the held symbol out first, so wait for room
                if (!(is_leaf && pend_valid_reg && !out_free))
                begin
                    if (is_leaf)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_sym_next   = pend_sym_reg;
                            out_end_next   = pend_end_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_sym_next   = child[SYM_W-1:0];
                        pend_end_next   = (child[SYM_W-1:0] == end_sym_reg);
                        walk_next       = ROOT_CODE;
                    end
                    else
                    begin
                        walk_next = child;
                    end
                    shift_next   = {shift_reg[BYTE_W-2:0], 1'b0};
                    bit_cnt_next = bit_cnt_reg + CNT_W'(1);
                    state_next   = (bit_cnt_reg == {CNT_W{1'b1}}) ? ST_FLUSH : ST_READ;
                end
            end
            ST_FLUSH:
            begin
                // the symbol still held is the byte's final one
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sym_next    = pend_sym_reg;
                    out_end_next    = pend_end_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            walk_reg       <= ROOT_CODE;
            bit_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            walk_reg       <= walk_next;
            bit_cnt_reg    <= bit_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        shift_reg    <= shift_next;
        pend_sym_reg <= pend_sym_next;
        pend_end_reg <= pend_end_next;
        out_sym_reg  <= out_sym_next;
        out_end_reg  <= out_end_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign symbol    = out_sym_reg;
    assign is_end    = out_end_reg;
    assign last      = out_last_reg;

    // checks
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("symbol held over while idle");

    a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (bit_cnt_reg == '0))
        else $error("bit count not back to zero at end of byte");

    a_walk_internal: assert property (@(posedge clk) disable iff (!rst_n)
        walk_reg >= NODE_W'(SYMBOL_COUNT))
        else $error("walk parked on a leaf");

    a_flush_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH && pend_valid_reg && out_free)
        |=> (out_valid_reg && out_last_reg))
        else $error("final symbol of byte not marked last");

endmodule
